// ===== design/smaf_pkg.sv =====
// Shared constants, FSM state type and controller command bundle for the moving average filter.
package smaf_pkg;

    localparam int READING_W        = 12;
    localparam int SAMPLES_W        = 4;
    localparam int WINDOW_DEPTH_DEF = 8;
    localparam int NUM_CHANNELS_DEF = 2;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_UPDATE = 4'b0010,
        ST_DIVIDE = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

    typedef struct packed {
        logic accept;    // capture input, issue history read
        logic update;    // write history, update sum/fill/pointer, load divider
        logic div_step;  // one quotient bit
        logic out_load;  // move result to output register
    } cmd_t;

endpackage

// ===== design/sensor_moving_average_filter.sv =====
// Per item: accept (ST_IDLE), update (ST_UPDATE), divide (ST_DIVIDE), output load (ST_DONE).
// in_stall holds off new items outside ST_IDLE; the restoring divider, one quotient bit
// per cycle over SUM_W = 12 + clog2(WINDOW_DEPTH) bits, takes most of that time.
// A finished result waits in the output register while the next item is taken.
// Reset (rst_n, async, active low) clears fill counts, sums and pointers; no clearing pass.
module sensor_moving_average_filter
    import smaf_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        channel,
    input  logic signed [READING_W-1:0] raw_reading,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [READING_W-1:0] average,
    output logic [SAMPLES_W-1:0]        samples_used
);

    localparam int SUM_W = READING_W + $clog2(WINDOW_DEPTH);

    cmd_t cmd;

    smaf_ctrl #(
        .SUM_W (SUM_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    smaf_dp #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .NUM_CHANNELS (NUM_CHANNELS),
        .SUM_W        (SUM_W)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .channel      (channel),
        .raw_reading  (raw_reading),
        .average      (average),
        .samples_used (samples_used)
    );

endmodule

// ===== design/smaf_ctrl.sv =====
// Controller FSM: input/output handshakes and sequencing of the divider.
module smaf_ctrl
    import smaf_pkg::*;
#(
    parameter int SUM_W = READING_W + 3
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    output logic out_valid,
    input  logic out_stall,
    output cmd_t cmd
);

    localparam int CNT_W = $clog2(SUM_W + 1);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(SUM_W - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== design/smaf_dp.sv =====
// Datapath: history memory, per-channel running sums and fill counts, restoring divider.
module smaf_dp
    import smaf_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int SUM_W        = READING_W + $clog2(WINDOW_DEPTH)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cmd_t                        cmd,
    input  logic                        channel,
    input  logic signed [READING_W-1:0] raw_reading,
    output logic signed [READING_W-1:0] average,
    output logic [SAMPLES_W-1:0]        samples_used
);

    localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int PTR_W  = $clog2(WINDOW_DEPTH);
    localparam int FC_W   = $clog2(WINDOW_DEPTH + 1);
    localparam int MEM_D  = NUM_CHANNELS * WINDOW_DEPTH;
    localparam int ADDR_W = $clog2(MEM_D);

    // history store, one circular window per channel
    logic signed [READING_W-1:0] mem [MEM_D];

    logic [PTR_W-1:0]        ptr_reg  [NUM_CHANNELS];
    logic [FC_W-1:0]         fill_reg [NUM_CHANNELS];
    logic signed [SUM_W-1:0] sum_reg  [NUM_CHANNELS];

    logic [CH_W-1:0]             ch_in;
    logic [ADDR_W-1:0]           addr_in;
    logic [CH_W-1:0]             ch_reg;
    logic [ADDR_W-1:0]           addr_reg;
    logic signed [READING_W-1:0] reading_reg;
    logic signed [READING_W-1:0] old_reg;

    logic                    full;
    logic [FC_W-1:0]         fill_next;
    logic [PTR_W-1:0]        ptr_next;
    logic signed [SUM_W-1:0] sum_next;
    logic signed [SUM_W-1:0] drop;

    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [FC_W:0]     rem_reg, rem_next;
    logic [FC_W-1:0]   div_reg;
    logic              neg_reg;
    logic [FC_W:0]     trial;
    logic              ge;

    logic [SUM_W-1:0]           avg_full;
    logic [SAMPLES_W+FC_W-1:0]  samples_ext;
    logic signed [READING_W-1:0] average_reg;
    logic [SAMPLES_W-1:0]       samples_reg;
    logic [FC_W-1:0]            count_reg;

    // channel number taken modulo the channel count
    assign ch_in   = (NUM_CHANNELS > 1) ? CH_W'(channel) : '0;
    assign addr_in = ADDR_W'(ch_in) * ADDR_W'(WINDOW_DEPTH) + ADDR_W'(ptr_reg[ch_in]);

    // once the window is full the slot under the pointer holds the oldest reading
    assign full      = (fill_reg[ch_reg] == FC_W'(WINDOW_DEPTH));
    assign fill_next = full ? fill_reg[ch_reg] : fill_reg[ch_reg] + FC_W'(1);
    assign ptr_next  = (ptr_reg[ch_reg] == PTR_W'(WINDOW_DEPTH - 1)) ? '0
                                                                     : ptr_reg[ch_reg] + PTR_W'(1);
    assign drop      = full ? SUM_W'(old_reg) : '0;
    assign sum_next  = sum_reg[ch_reg] + SUM_W'(reading_reg) - drop;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            old_reg <= mem[addr_in];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            mem[addr_reg] <= reading_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            ch_reg      <= ch_in;
            addr_reg    <= addr_in;
            reading_reg <= raw_reading;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                ptr_reg[i]  <= '0;
                fill_reg[i] <= '0;
                sum_reg[i]  <= '0;
            end
        end
        else if (cmd.update)
        begin
            ptr_reg[ch_reg]  <= ptr_next;
            fill_reg[ch_reg] <= fill_next;
            sum_reg[ch_reg]  <= sum_next;
        end
    end

    // restoring division of |sum| by the fill count, one quotient bit per cycle
    assign trial    = {rem_reg[FC_W-1:0], quo_reg[SUM_W-1]};
    assign ge       = (trial >= {1'b0, div_reg});
    assign rem_next = ge ? trial - {1'b0, div_reg} : trial;
    assign quo_next = {quo_reg[SUM_W-2:0], ge};

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            quo_reg   <= sum_next[SUM_W-1] ? SUM_W'(-sum_next) : SUM_W'(sum_next);
            neg_reg   <= sum_next[SUM_W-1];
            rem_reg   <= '0;
            div_reg   <= fill_next;
            count_reg <= fill_next;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign avg_full    = neg_reg ? SUM_W'(-quo_reg) : quo_reg;
    assign samples_ext = {{SAMPLES_W{1'b0}}, count_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            average_reg <= avg_full[READING_W-1:0];
            samples_reg <= samples_ext[SAMPLES_W-1:0];
        end
    end

    assign average      = average_reg;
    assign samples_used = samples_reg;

endmodule

// ===== bench/sensor_moving_average_filter_checker.sv =====
// Transfer monitor, per-channel window predictor and result scoreboard for the moving average filter.
module sensor_moving_average_filter_checker
    import smaf_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic                        channel,
    input  logic signed [READING_W-1:0] raw_reading,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic signed [READING_W-1:0] average,
    input  logic [SAMPLES_W-1:0]        samples_used,
    output int                          errors,
    output int                          pending,
    output int                          checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [READING_W-1:0] average;
        logic [SAMPLES_W-1:0]        samples_used;
    } mean_result_t;

    // newest reading at index 0
    logic signed [READING_W:0] readings [NUM_CHANNELS][WINDOW_DEPTH];
    int unsigned               filled [NUM_CHANNELS];
    mean_result_t              expected_means [$];

    int mismatch_count = 0;
    int outstanding    = 0;
    int result_count   = 0;

    assign errors  = mismatch_count;
    assign pending = outstanding;
    assign checked = result_count;

    // Push a reading into its channel window and return the truncated mean.
    function automatic mean_result_t window_mean(input logic ch_in,
                                                 input logic signed [READING_W-1:0] reading);
        int           slot;
        int           k;
        int           total;
        int           mean;
        mean_result_t res;
        slot = int'(ch_in) % NUM_CHANNELS;
        for (k = WINDOW_DEPTH - 1; k > 0; k--)
            readings[slot][k] = readings[slot][k - 1];
        readings[slot][0] = reading;
        if (filled[slot] < WINDOW_DEPTH)
            filled[slot]++;
        total = 0;
        for (k = 0; k < int'(filled[slot]); k++)
            total += readings[slot][k];
        mean = total / int'(filled[slot]);   // truncates toward zero
        res.average      = READING_W'(mean);
        res.samples_used = SAMPLES_W'(filled[slot]);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        mean_result_t exp_res;
        int           c;
        if (!rst_n)
        begin
            for (c = 0; c < NUM_CHANNELS; c++)
                filled[c] = 0;
            expected_means.delete();
            outstanding = 0;
        end
        else
        begin
            // check first: a result can't belong to an input taken at the same edge
            if (out_valid && !out_stall)
            begin
                result_count++;
                if (expected_means.size() == 0)
                begin
                    $error("result transfer with nothing expected: average %0d samples_used %0d",
                           average, samples_used);
                    mismatch_count++;
                end
                else
                begin
                    exp_res = expected_means.pop_front();
                    if (average !== exp_res.average)
                    begin
                        $error("average mismatch: expected %0d, got %0d",
                               exp_res.average, average);
                        mismatch_count++;
                    end
                    if (samples_used !== exp_res.samples_used)
                    begin
                        $error("samples_used mismatch: expected %0d, got %0d",
                               exp_res.samples_used, samples_used);
                        mismatch_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_means.push_back(window_mean(channel, raw_reading));
            outstanding = expected_means.size();
        end
    end

endmodule

// ===== bench/sensor_moving_average_filter_test.sv =====
// Stimulus, handshake pacing and verdict for the moving average filter bench.
module sensor_moving_average_filter_test
    import smaf_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES = 200;

    logic                        clk         = 1'b0;
    logic                        rst_n       = 1'b0;
    logic                        in_valid    = 1'b0;
    logic                        in_stall;
    logic                        channel     = 1'b0;
    logic signed [READING_W-1:0] raw_reading = '0;
    logic                        out_valid;
    logic                        out_stall   = 1'b0;
    logic signed [READING_W-1:0] average;
    logic [SAMPLES_W-1:0]        samples_used;

    int          errors;
    int          pending;
    int          checked;
    int          sent_count  = 0;
    int unsigned idle_pct    = 0;
    int unsigned stall_pct   = 0;
    logic        hold_active = 1'b0;
    event        hold_start;

    sensor_moving_average_filter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .channel      (channel),
        .raw_reading  (raw_reading),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .average      (average),
        .samples_used (samples_used)
    );

    sensor_moving_average_filter_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .channel      (channel),
        .raw_reading  (raw_reading),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .average      (average),
        .samples_used (samples_used),
        .errors       (errors),
        .pending      (pending),
        .checked      (checked)
    );

    always #1 clk = ~clk;

    // long output hold-off; toggles at posedge, read at negedge
    always
    begin
        @(hold_start);
        hold_active = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active = 1'b0;
    end

    always @(negedge clk)
        out_stall <= hold_active || ($urandom_range(99) < stall_pct);

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_reading(input logic ch, input logic signed [READING_W-1:0] value);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        channel     <= ch;
        raw_reading <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent_count++;
        @(negedge clk);
    endtask

    function automatic logic signed [READING_W-1:0] random_reading();
        int pick;
        int v;
        pick = $urandom_range(9);
        if (pick < 6)
            v = int'($urandom_range(2880)) - 880;         // sensor range
        else if (pick < 8)
            v = int'($urandom_range(4095)) - 2048;        // any 12-bit pattern
        else
        begin
            case ($urandom_range(5))
                0:       v = -2048;
                1:       v = 2047;
                2:       v = -880;
                3:       v = 2000;
                4:       v = -1;
                default: v = 0;
            endcase
        end
        return READING_W'(v);
    endfunction

    initial
    begin
        int unsigned idle_mix [4];
        int unsigned stall_mix [4];
        int          p;
        idle_mix  = '{0, 56, 0, 27};
        stall_mix = '{0, 0, 56, 27};

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: extremes, truncation of negative means, window saturation
        send_reading(1'b0, 12'sd2047);
        send_reading(1'b0, -12'sd2048);
        send_reading(1'b0, -12'sd3);
        send_reading(1'b1, -12'sd880);
        send_reading(1'b1, 12'sd2000);
        send_reading(1'b1, -12'sd1);
        send_reading(1'b1, 12'sd1);
        repeat (9) send_reading(1'b0, 12'sd2047);
        repeat (8) send_reading(1'b1, -12'sd2048);

        for (p = 0; p < 4; p++)
        begin
            idle_pct  = idle_mix[p];
            stall_pct = stall_mix[p];
            repeat (110) send_reading(1'($urandom_range(1)), random_reading());
        end

        // output held off while input keeps coming, so the block backs up
        idle_pct  = 0;
        stall_pct = 0;
        -> hold_start;
        repeat (60) send_reading(1'($urandom_range(1)), random_reading());

        // drain completely before resuming
        in_valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
        idle_pct  = 27;
        stall_pct = 27;
        repeat (50) send_reading(1'($urandom_range(1)), random_reading());
        in_valid <= 1'b0;

        wait (pending == 0);
        repeat (40) @(posedge clk);

        $display("Run: %0d readings over both channels, %0d averages checked",
                 sent_count, checked);
        $display("Covered warmup, window saturation, full-range readings, backpressure and drain");
        if (errors == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #400_000;
        $display("simulation failed");
        $finish;
    end

endmodule
